// ===== hdl/olst_pkg.sv =====
package olst_pkg;

	localparam int REQ_W  = 3;
	localparam int VAL_W  = 32;
	localparam int POS_W  = 5;
	localparam int STAT_W = 2;

	localparam logic [REQ_W-1:0] REQ_INS_HEAD = 3'd0;
	localparam logic [REQ_W-1:0] REQ_INS_TAIL = 3'd1;
	localparam logic [REQ_W-1:0] REQ_INS_POS  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_DEL_HEAD = 3'd3;
	localparam logic [REQ_W-1:0] REQ_DEL_TAIL = 3'd4;
	localparam logic [REQ_W-1:0] REQ_READ_ALL = 3'd5;

	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;
	localparam logic [STAT_W-1:0] STAT_RANGE = 2'd3;

	typedef logic [VAL_W-1:0] elem_t;

endpackage

// ===== hdl/olst_ram.sv =====
module olst_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/ordered_list_store.sv =====
// Bounded ordered list of up to DEPTH signed 32-bit values, head to tail.
// Request channel (req_*): one item per request; req_type selects insert at
// head, tail or 1-based position, delete head or tail, or read out the list.
// Result channel (res_*): one item per request, or one per element for a
// read-out, head first, with last set on the final item of the request.
// A refused request gives one item with a non-zero status and zero value.
// One request is worked at a time; req_ready is high only between requests.
// Work per request, n = elements stored, p = insert position:
//   insert: entries from p onward move up one per cycle, then the new
//     value is written; no entry moves for an insert at the tail
//   delete head: the head is taken, the rest move down one per cycle
//   delete tail: a single memory read; read-out: S_READ, S_CAPT, S_EMIT per element
//   refused request: no memory access; unknown code: no item
// The shift rate is one entry per cycle through the single read and write
// port of the element memory; a read-out needs a memory read per element.
// The result register frees the request side: a new request is taken while
// a result waits, and the block stalls only when its next result finds the
// register still full. Reset empties the list at once (no clearing pass);
// entries are only read below the element count.
module ordered_list_store #(
	parameter int DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_ready,
	input  logic [olst_pkg::REQ_W-1:0]       req_type,
	input  logic signed [olst_pkg::VAL_W-1:0] value,
	input  logic [olst_pkg::POS_W-1:0]       position,
	output logic                             res_valid,
	input  logic                             res_ready,
	output logic [olst_pkg::STAT_W-1:0]      status,
	output logic signed [olst_pkg::VAL_W-1:0] value_res,
	output logic                             last
);

	import olst_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MOVE = 3'd1;
	localparam logic [2:0] S_READ = 3'd2;
	localparam logic [2:0] S_CAPT = 3'd3;
	localparam logic [2:0] S_EMIT = 3'd4;

	logic [2:0]        state_q;
	logic [CW-1:0]     count_q;
	logic [AW-1:0]     src_q;
	logic [CW-1:0]     left_q;
	logic              del_q;
	logic [AW-1:0]     ins_idx_q;
	elem_t             ins_val_q;
	logic              ra_q;
	logic [AW-1:0]     rd_q;
	logic              mv_s1;
	logic              first_s1;
	logic [AW-1:0]     dst_s1;
	logic [STAT_W-1:0] pend_stat_q;
	elem_t             pend_val_q;
	logic              pend_last_q;
	logic              res_valid_q;
	logic [STAT_W-1:0] status_q;
	elem_t             value_q;
	logic              last_q;

	logic              we;
	logic [AW-1:0]     waddr;
	elem_t             wdata;
	logic [AW-1:0]     raddr;
	elem_t             rdata;

	logic [PW-1:0]     pos_ext;
	logic [PW-1:0]     cnt_ext;
	logic              pos_ok;
	logic [AW-1:0]     idx;
	logic              full;
	logic              empty;
	logic              emit_go;

	assign pos_ext = PW'(position);
	assign cnt_ext = PW'(count_q);
	assign pos_ok  = (position != '0) && (pos_ext <= cnt_ext + PW'(1));
	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign emit_go = (state_q == S_EMIT) && (!res_valid_q || res_ready);

	always_comb begin
		case (req_type) inside
			REQ_INS_HEAD: idx = '0;
			REQ_INS_TAIL: idx = count_q[AW-1:0];
			default:      idx = AW'(pos_ext - PW'(1));
		endcase
	end

	always_comb begin
		we    = 1'b0;
		waddr = dst_s1;
		wdata = rdata;
		raddr = (state_q == S_READ) ? rd_q : src_q;
		if (state_q == S_MOVE) begin
			if (mv_s1) begin
				we = !first_s1;
			end else if (left_q == '0 && !del_q) begin
				we    = 1'b1;
				waddr = ins_idx_q;
				wdata = ins_val_q;
			end
		end
	end

	olst_ram #(
		.WIDTH(VAL_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			src_q       <= '0;
			left_q      <= '0;
			del_q       <= 1'b0;
			ins_idx_q   <= '0;
			ins_val_q   <= '0;
			ra_q        <= 1'b0;
			rd_q        <= '0;
			mv_s1       <= 1'b0;
			first_s1    <= 1'b0;
			dst_s1      <= '0;
			pend_stat_q <= STAT_OK;
			pend_val_q  <= '0;
			pend_last_q <= 1'b0;
			res_valid_q <= 1'b0;
			status_q    <= STAT_OK;
			value_q     <= '0;
			last_q      <= 1'b0;
		end else begin
			if (emit_go)
				res_valid_q <= 1'b1;
			else if (res_valid_q && res_ready)
				res_valid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						ra_q        <= 1'b0;
						pend_val_q  <= '0;
						pend_last_q <= 1'b1;
						case (req_type) inside
							REQ_INS_HEAD, REQ_INS_TAIL, REQ_INS_POS: begin
								if (full) begin
									pend_stat_q <= STAT_FULL;
									state_q     <= S_EMIT;
								end else if (req_type == REQ_INS_POS && !pos_ok) begin
									pend_stat_q <= STAT_RANGE;
									state_q     <= S_EMIT;
								end else begin
									ins_idx_q <= idx;
									ins_val_q <= value;
									left_q    <= count_q - CW'(idx);
									src_q     <= AW'(count_q - CW'(1));
									del_q     <= 1'b0;
									state_q   <= S_MOVE;
								end
							end
							REQ_DEL_HEAD: begin
								if (empty) begin
									pend_stat_q <= STAT_EMPTY;
									state_q     <= S_EMIT;
								end else begin
									left_q  <= count_q;
									src_q   <= '0;
									del_q   <= 1'b1;
									state_q <= S_MOVE;
								end
							end
							REQ_DEL_TAIL: begin
								if (empty) begin
									pend_stat_q <= STAT_EMPTY;
									state_q     <= S_EMIT;
								end else begin
									rd_q    <= AW'(count_q - CW'(1));
									count_q <= count_q - CW'(1);
									state_q <= S_READ;
								end
							end
							REQ_READ_ALL: begin
								if (empty) begin
									pend_stat_q <= STAT_EMPTY;
									state_q     <= S_EMIT;
								end else begin
									rd_q    <= '0;
									ra_q    <= 1'b1;
									state_q <= S_READ;
								end
							end
							default: ;
						endcase
					end
				end
				S_MOVE: begin
					if (left_q != '0) begin
						mv_s1    <= 1'b1;
						first_s1 <= del_q && (src_q == '0);
						dst_s1   <= del_q ? src_q - AW'(1) : src_q + AW'(1);
						src_q    <= del_q ? src_q + AW'(1) : src_q - AW'(1);
						left_q   <= left_q - CW'(1);
					end else begin
						mv_s1 <= 1'b0;
					end
					// removed head value arrives in the cycle after its read
					if (mv_s1 && first_s1)
						pend_val_q <= rdata;
					if (left_q == '0 && !mv_s1) begin
						count_q     <= del_q ? count_q - CW'(1) : count_q + CW'(1);
						pend_stat_q <= STAT_OK;
						pend_last_q <= 1'b1;
						state_q     <= S_EMIT;
					end
				end
				S_READ: begin
					state_q <= S_CAPT;
				end
				S_CAPT: begin
					pend_val_q  <= rdata;
					pend_stat_q <= STAT_OK;
					pend_last_q <= !ra_q || ((CW'(rd_q) + CW'(1)) == count_q);
					state_q     <= S_EMIT;
				end
				S_EMIT: begin
					if (emit_go) begin
						status_q    <= pend_stat_q;
						value_q     <= pend_val_q;
						last_q      <= pend_last_q;
						if (ra_q && !pend_last_q) begin
							rd_q    <= rd_q + AW'(1);
							state_q <= S_READ;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req_ready = (state_q == S_IDLE);
	assign res_valid = res_valid_q;
	assign status    = status_q;
	assign value_res = value_q;
	assign last      = last_q;

endmodule

// ===== hdl/olst_chk.sv =====
module olst_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              res_valid,
	input logic                              res_ready,
	input logic [olst_pkg::STAT_W-1:0]       status,
	input logic signed [olst_pkg::VAL_W-1:0] value_res,
	input logic                              last
);

	import olst_pkg::*;

	a_refused_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status != STAT_OK |-> last)
		else $error("refused request result without last");

	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status != STAT_OK |-> value_res == '0)
		else $error("refused request result carries a value");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(value_res) && $stable(last))
		else $error("result changed while stalled");

endmodule

bind ordered_list_store olst_chk u_olst_chk (.*);

// ===== bench/ordered_list_store_checker.sv =====
`timescale 1ns / 100ps

module ordered_list_store_checker #(
	parameter int DEPTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	input  logic                          req_ready,
	input  logic [olst_pkg::REQ_W-1:0]    req_type,
	input  logic [olst_pkg::VAL_W-1:0]    value,
	input  logic [olst_pkg::POS_W-1:0]    position,
	input  logic                          res_valid,
	input  logic                          res_ready,
	input  logic [olst_pkg::STAT_W-1:0]   status,
	input  logic [olst_pkg::VAL_W-1:0]    value_res,
	input  logic                          last,
	output int                            mismatches,
	output int                            outstanding
);

	import olst_pkg::*;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		elem_t             val;
		logic              last;
	} outcome_t;

	elem_t    shadow_list[$];
	outcome_t awaited[$];

	function automatic void await_outcome(logic [STAT_W-1:0] st, elem_t v, logic fin);
		outcome_t o;
		o.status = st;
		o.val = v;
		o.last = fin;
		awaited.push_back(o);
	endfunction

	// Applies one request to the shadow list and queues the items it gives.
	function automatic void apply_request(logic [REQ_W-1:0] kind, elem_t v,
			logic [POS_W-1:0] pos);
		int n;
		n = shadow_list.size();
		case (kind)
		REQ_INS_HEAD, REQ_INS_TAIL, REQ_INS_POS: begin
			if (n >= DEPTH) begin
				await_outcome(STAT_FULL, '0, 1'b1);
			end else if (kind == REQ_INS_POS && (pos == 0 || int'(pos) > n + 1)) begin
				await_outcome(STAT_RANGE, '0, 1'b1);
			end else begin
				if (kind == REQ_INS_HEAD)
					shadow_list.push_front(v);
				else if (kind == REQ_INS_TAIL)
					shadow_list.push_back(v);
				else
					shadow_list.insert(int'(pos) - 1, v);
				await_outcome(STAT_OK, '0, 1'b1);
			end
		end
		REQ_DEL_HEAD: begin
			if (n == 0)
				await_outcome(STAT_EMPTY, '0, 1'b1);
			else
				await_outcome(STAT_OK, shadow_list.pop_front(), 1'b1);
		end
		REQ_DEL_TAIL: begin
			if (n == 0)
				await_outcome(STAT_EMPTY, '0, 1'b1);
			else
				await_outcome(STAT_OK, shadow_list.pop_back(), 1'b1);
		end
		REQ_READ_ALL: begin
			if (n == 0)
				await_outcome(STAT_EMPTY, '0, 1'b1);
			else
				foreach (shadow_list[i])
					await_outcome(STAT_OK, shadow_list[i], i == n - 1);
		end
		default: ;	// spare codes: no item, no change
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t seen;
		outcome_t want;
		if (!arst_n) begin
			shadow_list.delete();
			awaited.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			// results first: an item accepted now always belongs to an older request
			if (res_valid && res_ready) begin
				seen.status = status;
				seen.val = value_res;
				seen.last = last;
				if (awaited.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected item: status %0d value %0d last %0b",
						$time, seen.status, $signed(seen.val), seen.last);
				end else begin
					want = awaited.pop_front();
					if (seen.status !== want.status || seen.val !== want.val ||
							seen.last !== want.last) begin
						mismatches++;
						$display("%0t: expected status %0d value %0d last %0b, got status %0d value %0d last %0b",
							$time, want.status, $signed(want.val), want.last,
							seen.status, $signed(seen.val), seen.last);
					end
				end
			end
			if (req_valid && req_ready)
				apply_request(req_type, value, position);
			outstanding = awaited.size();
		end
	end

endmodule

// ===== bench/ordered_list_store_tb.sv =====
`timescale 1ns / 100ps

module ordered_list_store_tb;
	import olst_pkg::*;

	localparam int DEPTH        = 16;
	localparam int RANDOM_ITEMS = 120;
	localparam int HOLD_AFTER   = 40;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 64;

	localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd6;
	localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;

	typedef enum int {SINK_FREE, SINK_HALF, SINK_SPARSE, SINK_TOGGLE} sink_mode_t;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     req_valid;
	logic                     req_ready;
	logic [REQ_W-1:0]         req_type;
	logic signed [VAL_W-1:0]  value;
	logic [POS_W-1:0]         position;
	logic                     res_valid;
	logic                     res_ready;
	logic [STAT_W-1:0]        status;
	logic signed [VAL_W-1:0]  value_res;
	logic                     last;

	int mismatches;
	int outstanding;
	int sent = 0;
	int burst_left = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	ordered_list_store #(
		.DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_type(req_type),
		.value(value),
		.position(position),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.status(status),
		.value_res(value_res),
		.last(last)
	);

	ordered_list_store_checker #(
		.DEPTH(DEPTH)
	) u_watch (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_type(req_type),
		.value(value),
		.position(position),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.status(status),
		.value_res(value_res),
		.last(last),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	// Offers one request, then either carries on the burst or idles a while.
	task automatic send_request(logic [REQ_W-1:0] kind, elem_t v, logic [POS_W-1:0] pos);
		int gap;
		req_valid <= 1'b1;
		req_type <= kind;
		value <= v;
		position <= pos;
		do @(posedge clk); while (!req_ready);
		sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) :
				$urandom_range(0, 10);
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic elem_t pick_value();
		case ($urandom_range(0, 7))
		0: return 32'h8000_0000;
		1: return 32'h7FFF_FFFF;
		2: return 32'h0000_0000;
		3: return 32'hFFFF_FFFF;
		default: return $urandom();
		endcase
	endfunction

	function automatic logic [POS_W-1:0] pick_position();
		if ($urandom_range(0, 9) == 0)
			return POS_W'($urandom_range(0, 31));
		return POS_W'($urandom_range(1, DEPTH + 1));
	endfunction

	initial begin
		#5_000_000;
		$display("ordered_list_store verification failed");
		$finish;
	end

	initial begin
		sink_mode_t mode;
		int stretch;
		bit held;
		held = 1'b0;
		res_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			mode = sink_mode_t'($urandom_range(0, 3));
			stretch = $urandom_range(10, 60);
			repeat (stretch) begin
				@(posedge clk);
				if (!held && sent >= HOLD_AFTER) begin
					// long hold-off so the result side backs up into the request side
					held = 1'b1;
					res_ready <= 1'b0;
					repeat (HOLD_CYCLES) @(posedge clk);
				end else begin
					case (mode)
					SINK_FREE:   res_ready <= 1'b1;
					SINK_HALF:   res_ready <= 1'($urandom_range(0, 1));
					SINK_SPARSE: res_ready <= ($urandom_range(0, 3) == 0);
					default:     res_ready <= ~res_ready;
					endcase
				end
			end
		end
	end

	initial begin
		logic [REQ_W-1:0] kind;
		int placed;
		int phase_len;
		int roll;
		bit filling;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_type = REQ_INS_HEAD;
		value = '0;
		position = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// empty list
		send_request(REQ_READ_ALL, 32'h1234_5678, 5'd1);
		send_request(REQ_DEL_HEAD, '0, '0);
		send_request(REQ_DEL_TAIL, '0, '0);
		send_request(REQ_INS_POS, 32'h8000_0000, 5'd0);
		// build a short list at the extremes
		send_request(REQ_INS_POS, 32'h8000_0000, 5'd1);
		send_request(REQ_INS_POS, 32'h0000_0001, 5'd3);
		send_request(REQ_INS_HEAD, 32'h7FFF_FFFF, 5'd0);
		send_request(REQ_INS_TAIL, 32'hFFFF_FFFF, 5'd31);
		send_request(REQ_INS_POS, 32'h5555_5555, 5'd2);
		send_request(REQ_INS_POS, 32'hAAAA_AAAA, 5'd5);
		send_request(REQ_INS_POS, 32'h0F0F_0F0F, 5'd31);
		send_request(REQ_DEL_HEAD, '1, '1);
		send_request(REQ_DEL_TAIL, '1, '1);
		send_request(REQ_SPARE_LO, '1, '1);
		send_request(REQ_SPARE_HI, '0, '0);
		// fill to capacity, then refused inserts and a full read-out
		for (int i = 0; i < DEPTH - 3; i++)
			send_request(REQ_INS_HEAD + REQ_W'(i % 3), pick_value(), 5'd1);
		send_request(REQ_INS_TAIL, 32'h0000_0000, 5'd0);
		send_request(REQ_INS_POS, 32'h0000_0000, 5'd0);
		send_request(REQ_READ_ALL, '0, '0);

		// alternate fill-heavy and drain-heavy stretches so both bounds recur
		placed = 0;
		filling = 1'b1;
		while (placed < RANDOM_ITEMS) begin
			phase_len = $urandom_range(6, 20);
			repeat (phase_len) begin
				roll = $urandom_range(0, 99);
				if (roll < 3)
					kind = ($urandom_range(0, 1) == 0) ? REQ_SPARE_LO : REQ_SPARE_HI;
				else if (roll < (filling ? 78 : 20))
					kind = REQ_INS_HEAD + REQ_W'($urandom_range(0, 2));
				else if (roll < 90)
					kind = REQ_DEL_HEAD + REQ_W'($urandom_range(0, 1));
				else
					kind = REQ_READ_ALL;
				send_request(kind, pick_value(), pick_position());
				if (kind != REQ_SPARE_LO && kind != REQ_SPARE_HI)
					placed++;
			end
			filling = !filling;
		end

		req_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("ordered_list_store verification clean");
		else
			$display("ordered_list_store verification failed");
		$finish;
	end

endmodule
